@@ rtl/iabd_pkg.sv @@
// Shared beat types, step table and index-adjust table for the IMA ADPCM byte decoder.
package iabd_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned POS_W    = 7;
    localparam int unsigned STEP_W   = 15;
    localparam int unsigned DIFF_W   = 17;
    localparam int unsigned SUM_W    = 18;

    localparam logic [POS_W-1:0] STEP_POS_MAX = 7'd88;

    localparam logic signed [SUM_W-1:0] SAMPLE_MAX = 18'sd32767;
    localparam logic signed [SUM_W-1:0] SAMPLE_MIN = -18'sd32768;

    localparam logic [3:0] NIBBLE_MASK = 4'h0F;

    // Command codes carried in the cmd field.
    localparam logic CMD_DECODE  = 1'b0;
    localparam logic CMD_SILENCE = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] code_byte;
        logic       start_clip;
        logic       low_only;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_out_beat;

    localparam logic [STEP_W-1:0] STEP_TABLE [0:88] = '{
        15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
        15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
        15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
        15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
        15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
        15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
        15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
        15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
        15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
        15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
        15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
        15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
        15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
    };

    // Index adjustment depends only on the magnitude bits of the code.
    function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
        logic signed [4:0] adj;
        case (mag)
            3'd4:    adj = 5'sd2;
            3'd5:    adj = 5'sd4;
            3'd6:    adj = 5'sd6;
            3'd7:    adj = 5'sd8;
            default: adj = -5'sd1;
        endcase
        return adj;
    endfunction

endpackage

@@ rtl/iabd_nibble_dec.sv @@
// Combinational decode of one 4-bit IMA ADPCM code into a new predictor and step position.
module iabd_nibble_dec
    import iabd_pkg::*;
(
    input  logic signed [SAMPLE_W-1:0] i_pred,
    input  logic        [POS_W-1:0]    i_pos,
    input  logic        [3:0]          i_code,
    output logic signed [SAMPLE_W-1:0] o_pred,
    output logic        [POS_W-1:0]    o_pos
);

    logic        [POS_W-1:0]  pos_c;
    logic        [STEP_W-1:0] step;
    logic        [DIFF_W-1:0] diff;
    logic signed [SUM_W-1:0]  sum;
    logic signed [POS_W+1:0]  np;

    always_comb begin
        pos_c = (i_pos > STEP_POS_MAX) ? STEP_POS_MAX : i_pos;
        step  = STEP_TABLE[pos_c];

        diff = {2'b00, (step >> 3)};
        if (i_code[0]) begin
            diff = diff + {2'b00, (step >> 2)};
        end
        if (i_code[1]) begin
            diff = diff + {2'b00, (step >> 1)};
        end
        if (i_code[2]) begin
            diff = diff + {2'b00, step};
        end

        if (i_code[3]) begin
            sum = SUM_W'(i_pred) - $signed({1'b0, diff});
        end else begin
            sum = SUM_W'(i_pred) + $signed({1'b0, diff});
        end

        if (sum > SAMPLE_MAX) begin
            o_pred = SAMPLE_MAX[SAMPLE_W-1:0];
        end else if (sum < SAMPLE_MIN) begin
            o_pred = SAMPLE_MIN[SAMPLE_W-1:0];
        end else begin
            o_pred = sum[SAMPLE_W-1:0];
        end

        np = $signed({2'b00, pos_c}) + (POS_W+2)'(index_adjust(i_code[2:0]));
        if (np < 0) begin
            o_pos = '0;
        end else if (np > $signed({2'b00, STEP_POS_MAX})) begin
            o_pos = STEP_POS_MAX;
        end else begin
            o_pos = np[POS_W-1:0];
        end
    end

endmodule

@@ rtl/ima_adpcm_byte_decoder_unit.sv @@
// Top level of the IMA ADPCM byte decoder: input holding register, nibble sequencing, result register.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------------------
//  in      | to block  | i_in_valid / o_in_ready    | i_in_data  (cmd, code_byte, start_clip,
//          |           |                            |             low_only)
//  out     | from block| o_out_valid / i_out_ready  | o_out_data (sample, last)
//
// A full byte is decoded one nibble at a time, low nibble first, because the high nibble
// needs the predictor and step position that the low nibble leaves; the single shared nibble
// decoder sets this. A silence beat or a low-nibble-only beat needs only one decode step.
// Reset (i_rst_n low at a clock edge) clears the predictor, the step position and all valid
// flags; the held payloads keep whatever they had.
// While the result register is full and not taken, decoding pauses; the next input beat is
// accepted into the holding register once it is empty or the current beat decodes its last nibble.
module ima_adpcm_byte_decoder_unit
    import iabd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    // Holding register for the input beat currently being decoded.
    logic     r_hold_valid, n_hold_valid;
    t_in_beat r_hold,       n_hold;
    // Low nibble (0) or high nibble (1) of the held byte.
    logic     r_phase,      n_phase;

    // Decoder state.
    logic signed [SAMPLE_W-1:0] r_pred, n_pred;
    logic        [POS_W-1:0]    r_pos,  n_pos;

    // Result register separating the decoder from the output handshake.
    logic      r_out_valid, n_out_valid;
    t_out_beat r_out,       n_out;

    logic                       out_free;
    logic                       fire;
    logic                       final_nib;
    logic signed [SAMPLE_W-1:0] eff_pred;
    logic        [POS_W-1:0]    eff_pos;
    logic        [3:0]          code;
    logic signed [SAMPLE_W-1:0] dec_pred;
    logic        [POS_W-1:0]    dec_pos;

    // A clip start clears the state before the first nibble of its beat is decoded.
    always_comb begin
        if (!r_phase && r_hold.start_clip) begin
            eff_pred = '0;
            eff_pos  = '0;
        end else begin
            eff_pred = r_pred;
            eff_pos  = r_pos;
        end
        code = (r_phase ? r_hold.code_byte[7:4] : r_hold.code_byte[3:0]) & NIBBLE_MASK;
    end

    iabd_nibble_dec u_nibble_dec (
        .i_pred (eff_pred),
        .i_pos  (eff_pos),
        .i_code (code),
        .o_pred (dec_pred),
        .o_pos  (dec_pos)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign fire       = r_hold_valid && out_free;
    // The beat is finished after this nibble for silence, low-only, or the high nibble.
    assign final_nib  = (r_hold.cmd == CMD_SILENCE) || r_hold.low_only || r_phase;
    assign o_in_ready = !r_hold_valid || (fire && final_nib);

    always_comb begin
        n_hold_valid = r_hold_valid;
        n_hold       = r_hold;
        n_phase      = r_phase;
        n_pred       = r_pred;
        n_pos        = r_pos;
        n_out_valid  = r_out_valid;
        n_out        = r_out;

        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (fire) begin
            n_out_valid = 1'b1;
            n_out.last  = final_nib;
            if (r_hold.cmd == CMD_SILENCE) begin
                // Silence leaves the state as it is, apart from a clip start.
                n_out.sample = '0;
                n_pred       = eff_pred;
                n_pos        = eff_pos;
            end else begin
                n_out.sample = dec_pred;
                n_pred       = dec_pred;
                n_pos        = dec_pos;
            end
            n_phase = !final_nib;
            if (final_nib) begin
                n_hold_valid = 1'b0;
            end
        end

        if (i_in_valid && o_in_ready) begin
            n_hold_valid = 1'b1;
            n_hold       = i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_phase      <= 1'b0;
            r_pred       <= '0;
            r_pos        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_hold_valid <= n_hold_valid;
            r_phase      <= n_phase;
            r_pred       <= n_pred;
            r_pos        <= n_pos;
            r_out_valid  <= n_out_valid;
        end
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The high nibble is only ever pending for a held full-byte decode beat.
    a_phase_only_full_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (r_hold_valid && (r_hold.cmd == CMD_DECODE) && !r_hold.low_only))
        else $error("high nibble pending without a full-byte beat");

    // The step position never leaves the table.
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= STEP_POS_MAX)
        else $error("step position out of range");

    // Decoding the high nibble always yields the closing beat of its input beat.
    a_high_nibble_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_phase) |=> (r_out_valid && r_out.last))
        else $error("high nibble result not marked last");

    // A silence request gives a single zero sample marked last.
    a_silence_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (r_hold.cmd == CMD_SILENCE)) |=> (r_out.sample == '0 && r_out.last))
        else $error("silence beat did not give a zero last sample");

    // The first nibble of a full byte is never marked last.
    a_low_nibble_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !final_nib) |=> (r_out_valid && !r_out.last && r_phase))
        else $error("low nibble of a full byte marked last");

endmodule
